[sv/eip_pkg.sv]
// shared types and constants for the expiring index pool
// no dependencies
package eip_pkg;
	localparam int STAMP_W = 63;
	localparam int SLOT_W = 10;
	localparam int CNT_W = 11;
	localparam logic [STAMP_W-1:0] FREE_MARK = {STAMP_W{1'b1}};

	typedef enum logic [1:0] {
		OP_BORROW  = 2'd0,
		OP_REFRESH = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_EXPIRY = 1'd0,
		REG_ACTIVE = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		op_t               op;
		logic [STAMP_W-1:0] now;
		logic [SLOT_W-1:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic               granted;
		logic [SLOT_W-1:0]  slot_out;
		logic               reclaimed;
		logic               held;
	} rsp_t;
endpackage

[sv/eip_front.sv]
// front part: two-entry command queue
// depends on eip_pkg
module eip_front import eip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  cmd_t        in_cmd,
	output logic        q_valid,
	output cmd_t        q_cmd,
	input  logic        q_pop
);
	cmd_t       buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

[sv/eip_back.sv]
// back part: stamp memory, clearing pass, slot scan and output register
// depends on eip_pkg
module eip_back import eip_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [STAMP_W-1:0] expiry_age,
	input  logic [CNT_W-1:0]   active_slots,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output rsp_t               out_rsp
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = AW + 1;

	logic [STAMP_W-1:0] mem [DEPTH];
	logic [STAMP_W-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          wen;
	logic [STAMP_W-1:0] wdata;

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [AW-1:0] idx_q, idx_d;
	logic [SW-1:0] left_q, left_d;
	logic [SW-1:0] size_q;
	logic [AW-1:0] scan_q;
	logic          out_v_q;
	rsp_t          rsp_q;
	logic          set_out, set_scan;
	logic [SW-1:0] size_c;
	logic          slot_in, exp_c, free_c;
	logic [STAMP_W-1:0] diff;

	// active count saturates to the table depth
	always_comb begin
		if (32'(active_slots) > 32'(DEPTH))
			size_c = SW'(DEPTH);
		else
			size_c = SW'(active_slots);
	end

	assign slot_in = (32'(q_cmd.slot) < 32'(size_c));
	assign diff = cmd_q.now - expiry_age;
	assign free_c = (rdata_q == FREE_MARK);
	assign exp_c = (cmd_q.now >= expiry_age) && (diff > rdata_q);

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		left_d = left_q;
		q_pop = 1'b0;
		wen = 1'b0;
		waddr = idx_q;
		wdata = cmd_q.now;
		raddr = idx_q;
		set_out = 1'b0;
		set_scan = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wen = 1'b1;
				wdata = FREE_MARK;
				idx_d = idx_q + AW'(1);
				if (idx_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
					idx_d = '0;
				end
			end
			ST_IDLE: begin
				if (q_valid && !out_v_q) begin
					q_pop = 1'b1;
					if (q_cmd.op == OP_BORROW) begin
						idx_d = ({1'b0, scan_q} < size_c) ? scan_q : '0;
						left_d = size_c;
						state_d = (size_c == '0) ? ST_OUT : ST_READ;
					end else begin
						idx_d = AW'(q_cmd.slot);
						left_d = slot_in ? SW'(1) : '0;
						state_d = (slot_in && q_cmd.op == OP_QUERY) ? ST_READ : ST_OUT;
						if (slot_in && q_cmd.op == OP_REFRESH) begin
							wen = 1'b1;
							waddr = AW'(q_cmd.slot);
							wdata = q_cmd.now;
						end
						if (slot_in && q_cmd.op == OP_RELEASE) begin
							wen = 1'b1;
							waddr = AW'(q_cmd.slot);
							wdata = FREE_MARK;
						end
					end
				end
			end
			ST_READ: begin
				raddr = idx_q;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (cmd_q.op == OP_QUERY) begin
					state_d = ST_OUT;
				end else if (free_c || exp_c) begin
					wen = 1'b1;
					set_scan = 1'b1;
					state_d = ST_OUT;
				end else begin
					left_d = left_q - SW'(1);
					if ({1'b0, idx_q} + SW'(1) >= size_q) idx_d = '0;
					else idx_d = idx_q + AW'(1);
					state_d = (left_q == SW'(1)) ? ST_OUT : ST_READ;
				end
			end
			ST_OUT: begin
				set_out = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			scan_q <= '0;
			out_v_q <= 1'b0;
			left_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			left_q <= left_d;
			if (set_scan) scan_q <= idx_q;
			if (set_out) out_v_q <= 1'b1;
			else if (out_v_q && !out_stall) out_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			size_q <= size_c;
			rsp_q <= {(q_cmd.op != OP_BORROW), {SLOT_W{1'b0}}, 1'b0, 1'b0};
		end else if (state_q == ST_CHECK) begin
			if (cmd_q.op == OP_QUERY)
				rsp_q.held <= !free_c && !exp_c;
			else if (free_c || exp_c) begin
				rsp_q.granted <= 1'b1;
				rsp_q.slot_out <= SLOT_W'(idx_q);
				rsp_q.reclaimed <= !free_c;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_rsp = rsp_q;
endmodule

[sv/expiring_index_pool_unit.sv]
// top level of the expiring index pool: config port, front queue, back scan
// depends on eip_pkg, eip_front, eip_back
//
// channel  | handshake           | payload
// in       | in_valid / in_stall | op, now, slot
// out      | out_valid/out_stall | granted, slot_out, reclaimed, held
// config   | apb write/read      | expiry_age (0x0), active_slots (0x8)
//
// refresh, release and out-of-range ops go from idle straight to the output; query reads
// and checks its slot first; borrow reads and checks one slot at a time, up to active_slots
// (capped at POOL_DEPTH), limited by the one read port of the stamp memory
// after reset a clearing pass writes every slot free; items queue in front meanwhile
// a stalled result holds the back part; the front queue keeps taking items until full
module expiring_index_pool_unit import eip_pkg::*; #(
	parameter int POOL_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [62:0] now,
	input  logic [9:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic [9:0]  slot_out,
	output logic        reclaimed,
	output logic        held
);
	logic [STAMP_W-1:0] expiry_q;
	logic [CNT_W-1:0]   active_q;
	logic               cfg_wr;
	reg_idx_t           ridx;
	cmd_t               in_cmd, q_cmd;
	logic               q_valid, q_pop;
	rsp_t               rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign ridx = reg_idx_t'(paddr[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= '0;
			active_q <= CNT_W'(1024);
		end else if (cfg_wr && paddr[2:0] == 3'd0) begin
			unique case (ridx)
				REG_EXPIRY: expiry_q <= pwdata[STAMP_W-1:0];
				REG_ACTIVE: active_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0) begin
			unique case (ridx)
				REG_EXPIRY: prdata = {1'b0, expiry_q};
				REG_ACTIVE: prdata = {53'd0, active_q};
				default: prdata = '0;
			endcase
		end
	end

	assign in_cmd.op = op_t'(op);
	assign in_cmd.now = now;
	assign in_cmd.slot = slot;

	eip_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	eip_back #(.DEPTH(POOL_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.expiry_age(expiry_q), .active_slots(active_q),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_rsp(rsp)
	);

	assign granted = rsp.granted;
	assign slot_out = rsp.slot_out;
	assign reclaimed = rsp.reclaimed;
	assign held = rsp.held;

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_reclaim_granted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reclaimed |-> granted) else $error("reclaim without grant");
	a_held_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held |-> slot_out == '0 && !reclaimed)
		else $error("query result carries slot");
endmodule
